/* rtl/tmbr_pkg.sv */
// Shared constants, types and a helper function for the tile map background renderer.
package tmbr_pkg;

  localparam int VRAM_BYTES    = 8192;
  localparam int VRAM_AW       = $clog2(VRAM_BYTES);
  localparam int BANK_DEPTH    = VRAM_BYTES / 2;
  localparam int BANK_AW       = $clog2(BANK_DEPTH);
  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 144;

  localparam int COORD_W = 8;
  localparam int SUM_W   = COORD_W + 1;
  localparam int FRAME_W = 15;
  localparam int PROD_W  = 2 * SUM_W;
  localparam int COLOR_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [VRAM_AW-1:0] MAP_BASE = VRAM_AW'(16'h1800);

  // Worst-case compare/subtract steps for (coord + scroll) mod screen size
  localparam int SUM_MAX      = 2 * ((1 << COORD_W) - 1);
  localparam int WRAP_X_STEPS = SUM_MAX / SCREEN_WIDTH;
  localparam int WRAP_Y_STEPS = SUM_MAX / SCREEN_HEIGHT;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_3 = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MAP   = 4'b0100,
    ST_PLANE = 4'b1000
  } state_t;

  // Request to the two-bank video memory (even and odd byte addresses)
  typedef struct packed {
    logic               wr_even;
    logic               wr_odd;
    logic [BANK_AW-1:0] wr_idx;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [BANK_AW-1:0] rd_idx_even;
    logic [BANK_AW-1:0] rd_idx_odd;
  } vram_req_t;

  function automatic logic [SUM_W-1:0] wrap_mod(input logic [SUM_W-1:0] v,
                                                input logic [SUM_W-1:0] m,
                                                input int               steps);
    logic [SUM_W-1:0] r;
    r = v;
    for (int i = 0; i < steps; i++) begin
      if (r >= m) r = r - m;
    end
    return r;
  endfunction

endpackage

/* rtl/tmbr_vram.sv */
// Video memory split into even and odd byte banks, one write and one read per bank per cycle.
module tmbr_vram
  import tmbr_pkg::*;
(
  input  logic      clk,
  input  vram_req_t req,
  output logic [7:0] even_q,
  output logic [7:0] odd_q
);

  logic [7:0] mem_even [BANK_DEPTH];
  logic [7:0] mem_odd  [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_even) mem_even[req.wr_idx] <= req.wr_data;
    if (req.rd_en)   even_q <= mem_even[req.rd_idx_even];
  end

  always_ff @(posedge clk) begin
    if (req.wr_odd) mem_odd[req.wr_idx] <= req.wr_data;
    if (req.rd_en)  odd_q <= mem_odd[req.rd_idx_odd];
  end

endmodule

/* rtl/tmbr_pos.sv */
// Scrolled framebuffer position: wraps column and row, then forms row * width + column.
module tmbr_pos
  import tmbr_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  logic [COORD_W-1:0] scroll_x,
  input  logic [COORD_W-1:0] scroll_y,
  output logic [FRAME_W-1:0] frame_index
);

  logic [SUM_W-1:0]  col_sum_r, row_sum_r;
  logic [SUM_W-1:0]  col_mod_r, row_mod_r;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      col_sum_r <= SUM_W'(pixel_x) + SUM_W'(scroll_x);
      row_sum_r <= SUM_W'(pixel_y) + SUM_W'(scroll_y);
    end
    col_mod_r <= wrap_mod(col_sum_r, SUM_W'(SCREEN_WIDTH), WRAP_X_STEPS);
    row_mod_r <= wrap_mod(row_sum_r, SUM_W'(SCREEN_HEIGHT), WRAP_Y_STEPS);
  end

  assign prod = PROD_W'(row_mod_r) * PROD_W'(SCREEN_WIDTH) + PROD_W'(col_mod_r);
  assign frame_index = prod[FRAME_W-1:0];

endmodule

/* rtl/tile_map_background_renderer.sv */
// Top level: control sequencer, configuration registers and result register.
//
// Write items do not make the block busy. A render item goes from transfer to result through
// the tile index read from the map, then the two bit-plane reads that depend on it, each a
// registered memory read, then the result register; a stalled result register holds the
// sequencer in its last step. The 8 KiB video memory is built as an even and an odd byte
// bank so both bit planes come in one read. After reset a clearing pass zeroes the memory,
// one address pair per cycle; in_stall stays high meanwhile while config writes are taken.
module tile_map_background_renderer
  import tmbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [VRAM_AW-1:0]   in_vram_address,
  input  logic [7:0]           in_vram_data,
  input  logic [COORD_W-1:0]   in_pixel_x,
  input  logic [COORD_W-1:0]   in_pixel_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAME_W-1:0]   out_frame_index,
  output logic [COLOR_W-1:0]   out_pixel_color
);

  state_t               state_r, state_nxt;
  logic [BANK_AW-1:0]   clr_cnt_r;
  logic [COORD_W-1:0]   scroll_x_r, scroll_y_r;
  logic [COLOR_W-1:0]   palette_r [4];
  logic [2:0]           px_r, py_r;
  logic                 map_odd_r;
  logic                 out_valid_r;
  logic [FRAME_W-1:0]   out_frame_index_r;
  logic [COLOR_W-1:0]   out_pixel_color_r;

  logic                 in_xfer, out_free, out_load;
  logic [VRAM_AW-1:0]   map_addr;
  logic [7:0]           even_q, odd_q, tile;
  logic [1:0]           pix_val;
  logic [2:0]           bit_sel;
  logic [BANK_AW-1:0]   plane_idx;
  logic [FRAME_W-1:0]   frame_index;
  vram_req_t            vreq;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_PLANE) && out_free;

  assign map_addr  = MAP_BASE + {3'b000, in_pixel_y[COORD_W-1:3], in_pixel_x[COORD_W-1:3]};
  assign tile      = map_odd_r ? odd_q : even_q;
  assign plane_idx = {1'b0, tile, py_r};
  assign bit_sel   = ~px_r;
  assign pix_val   = {odd_q[bit_sel], even_q[bit_sel]};

  always_comb begin
    vreq             = '0;
    vreq.wr_data     = in_vram_data;
    vreq.wr_idx      = in_vram_address[VRAM_AW-1:1];
    vreq.rd_idx_even = map_addr[VRAM_AW-1:1];
    vreq.rd_idx_odd  = map_addr[VRAM_AW-1:1];
    case (state_r)
      ST_CLEAR: begin
        vreq.wr_even = 1'b1;
        vreq.wr_odd  = 1'b1;
        vreq.wr_idx  = clr_cnt_r;
        vreq.wr_data = '0;
      end
      ST_IDLE: begin
        if (in_xfer && in_operation == OP_WRITE) begin
          vreq.wr_even = !in_vram_address[0];
          vreq.wr_odd  = in_vram_address[0];
        end
        if (in_xfer && in_operation == OP_RENDER) vreq.rd_en = 1'b1;
      end
      ST_MAP: begin
        vreq.rd_en       = 1'b1;
        vreq.rd_idx_even = plane_idx;
        vreq.rd_idx_odd  = plane_idx;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_xfer && in_operation == OP_RENDER) state_nxt = ST_MAP;
      ST_MAP:   state_nxt = ST_PLANE;
      ST_PLANE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      scroll_x_r  <= '0;
      scroll_y_r  <= '0;
      for (int i = 0; i < 4; i++) palette_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load)            out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SCROLL_X:  scroll_x_r   <= cfg_data[COORD_W-1:0];
          REG_SCROLL_Y:  scroll_y_r   <= cfg_data[COORD_W-1:0];
          REG_PALETTE_0: palette_r[0] <= cfg_data;
          REG_PALETTE_1: palette_r[1] <= cfg_data;
          REG_PALETTE_2: palette_r[2] <= cfg_data;
          REG_PALETTE_3: palette_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px_r      <= in_pixel_x[2:0];
      py_r      <= in_pixel_y[2:0];
      map_odd_r <= map_addr[0];
    end
    if (out_load) begin
      out_frame_index_r <= frame_index;
      out_pixel_color_r <= palette_r[pix_val];
    end
  end

  tmbr_vram u_vram (
    .clk    (clk),
    .req    (vreq),
    .even_q (even_q),
    .odd_q  (odd_q)
  );

  tmbr_pos u_pos (
    .clk         (clk),
    .load        (in_xfer),
    .pixel_x     (in_pixel_x),
    .pixel_y     (in_pixel_y),
    .scroll_x    (scroll_x_r),
    .scroll_y    (scroll_y_r),
    .frame_index (frame_index)
  );

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_frame_index_r;
  assign out_pixel_color = out_pixel_color_r;

endmodule

/* rtl/tmbr_checker.sv */
// Port-level checks for the tile map background renderer and their bind.
module tmbr_checker
  import tmbr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_operation,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FRAME_W-1:0] out_frame_index,
  input logic [COLOR_W-1:0] out_pixel_color
);

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_index)
                               && $stable(out_pixel_color))
    else $error("stalled result changed");

  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_RENDER |=> in_stall)
    else $error("render transfer did not make the block busy");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall && in_operation == OP_WRITE |=> !in_stall)
    else $error("write transfer held off the next item");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a render in progress");

endmodule

bind tile_map_background_renderer tmbr_checker u_tmbr_checker (.*);

/* tb/tile_map_background_renderer_tb.sv */
// Self-checking testbench for the tile map background renderer.
module tile_map_background_renderer_tb;
  import tmbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES       = 4;
  localparam int ITEMS_PER_PHASE  = 212;
  localparam int SETTLE_CYCLES    = 10;
  localparam int NUM_DIRECTED     = 22;
  localparam int NUM_CFG_INDEXES  = 1 << CFG_IDX_W;

  localparam logic [COLOR_W-1:0] DIR_PAL0 = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] DIR_PAL1 = 32'h0000_0000;
  localparam logic [COLOR_W-1:0] DIR_PAL2 = 32'h8000_0001;
  localparam logic [COLOR_W-1:0] DIR_PAL3 = 32'h7FFF_FFFE;

  typedef struct packed {
    logic               op;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         data;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } pixel_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [COLOR_W-1:0] color;
  } frame_pixel_t;

  typedef struct packed {
    pixel_req_t   req;
    logic         typed;
    frame_pixel_t res;
  } directed_row_t;

  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd0},   1'b1, '{15'd0,     DIR_PAL0}},
    '{'{OP_RENDER, 13'h1FFF, 8'hFF, 8'd159, 8'd143}, 1'b1, '{15'd23039, DIR_PAL0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd255, 8'd255}, 1'b1, '{15'd17855, DIR_PAL0}},
    '{'{OP_WRITE,  13'h1800, 8'hFF, 8'hFF,  8'hFF},  1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h0FF0, 8'h80, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h0FF1, 8'h01, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd7,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd1,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h0FF2, 8'hFF, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h0FF3, 8'hFF, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd3,   8'd1},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h1BFF, 8'h01, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h001E, 8'h01, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h001F, 8'h00, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h1FFF, 8'hFF, 8'd255, 8'd255}, 1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h1FFF, 8'hFF, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h0000, 8'hAA, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_WRITE,  13'h0001, 8'h55, 8'd0,   8'd0},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd200, 8'd100}, 1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd0,   8'd8},   1'b0, '{15'd0, 32'd0}},
    '{'{OP_RENDER, 13'h0000, 8'h00, 8'd1,   8'd8},   1'b0, '{15'd0, 32'd0}}
  };

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [COLOR_W-1:0]   cfg_data        = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic                 in_operation    = OP_WRITE;
  logic [VRAM_AW-1:0]   in_vram_address = '0;
  logic [7:0]           in_vram_data    = '0;
  logic [COORD_W-1:0]   in_pixel_x      = '0;
  logic [COORD_W-1:0]   in_pixel_y      = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [FRAME_W-1:0]   out_frame_index;
  logic [COLOR_W-1:0]   out_pixel_color;

  tile_map_background_renderer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_vram_address (in_vram_address),
    .in_vram_data    (in_vram_data),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_index (out_frame_index),
    .out_pixel_color (out_pixel_color)
  );

  logic [7:0]         vram_mirror [VRAM_BYTES];
  logic [7:0]         scroll_x_m;
  logic [7:0]         scroll_y_m;
  logic [COLOR_W-1:0] palette_m [4];
  frame_pixel_t       pending_pixels [$];
  int                 mismatches   = 0;
  int                 sender_idle  = 0;
  int                 stall_pct    = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic frame_pixel_t predict_pixel(logic [COORD_W-1:0] px,
                                                 logic [COORD_W-1:0] py);
    logic [VRAM_AW-1:0] map_addr;
    logic [VRAM_AW-1:0] row_addr;
    logic [7:0]         tile;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [2:0]         bitpos;
    logic [1:0]         value;
    int                 col;
    int                 row;
    frame_pixel_t       res;
    map_addr = MAP_BASE + VRAM_AW'({py[7:3], px[7:3]});
    tile     = vram_mirror[map_addr];
    row_addr = VRAM_AW'({tile, py[2:0], 1'b0});
    lo       = vram_mirror[row_addr];
    hi       = vram_mirror[row_addr + 1'b1];
    bitpos   = 3'd7 - px[2:0];
    value    = {hi[bitpos], lo[bitpos]};
    col      = (int'(px) + int'(scroll_x_m)) % SCREEN_WIDTH;
    row      = (int'(py) + int'(scroll_y_m)) % SCREEN_HEIGHT;
    res.frame = FRAME_W'(row * SCREEN_WIDTH + col);
    res.color = palette_m[value];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result transfer", 32'd0, out_frame_index);
      end else begin
        want = pending_pixels.pop_front();
        if (out_frame_index !== want.frame)
          report_mismatch("frame_index", want.frame, out_frame_index);
        if (out_pixel_color !== want.color)
          report_mismatch("pixel_color", want.color, out_pixel_color);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Called on a clock step; returns on the step after the transfer or after any idle gap.
  task automatic send_item(input pixel_req_t req, input logic typed = 1'b0,
                           input frame_pixel_t typed_res = '0);
    in_valid        <= 1'b1;
    in_operation    <= req.op;
    in_vram_address <= req.addr;
    in_vram_data    <= req.data;
    in_pixel_x      <= req.px;
    in_pixel_y      <= req.py;
    do @(posedge clk); while (in_stall);
    if (req.op == OP_WRITE) vram_mirror[req.addr] = req.data;
    else pending_pixels.push_back(typed ? typed_res : predict_pixel(req.px, req.py));
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic pixel_req_t make_write(logic [VRAM_AW-1:0] addr, logic [7:0] data);
    pixel_req_t req;
    req = '{OP_WRITE, addr, data, 8'($urandom_range(255)), 8'($urandom_range(255))};
    return req;
  endfunction

  function automatic pixel_req_t make_render(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    pixel_req_t req;
    req = '{OP_RENDER, VRAM_AW'($urandom_range(VRAM_BYTES - 1)), 8'($urandom_range(255)),
            px, py};
    return req;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every index, the unused ones included; scroll values carry junk upper bits.
  task automatic configure(input logic [7:0] sx, input logic [7:0] sy,
                           input logic [COLOR_W-1:0] p0, input logic [COLOR_W-1:0] p1,
                           input logic [COLOR_W-1:0] p2, input logic [COLOR_W-1:0] p3);
    logic [COLOR_W-1:0] value;
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < NUM_CFG_INDEXES; i++) begin
      idx = CFG_IDX_W'(i);
      case (idx)
        REG_SCROLL_X:  value = {24'($urandom), sx};
        REG_SCROLL_Y:  value = {24'($urandom), sy};
        REG_PALETTE_0: value = p0;
        REG_PALETTE_1: value = p1;
        REG_PALETTE_2: value = p2;
        REG_PALETTE_3: value = p3;
        default:       value = $urandom;
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      @(posedge clk);
      case (idx)
        REG_SCROLL_X:  scroll_x_m   = value[7:0];
        REG_SCROLL_Y:  scroll_y_m   = value[7:0];
        REG_PALETTE_0: palette_m[0] = value;
        REG_PALETTE_1: palette_m[1] = value;
        REG_PALETTE_2: palette_m[2] = value;
        REG_PALETTE_3: palette_m[3] = value;
        default: ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Map entry and both bit planes of one tile row, each sometimes skipped, then renders inside that row.
  task automatic send_tile_sequence(output int count);
    logic [4:0]         tx;
    logic [4:0]         ty;
    logic [2:0]         row;
    logic [7:0]         tile;
    logic [VRAM_AW-1:0] row_addr;
    int                 renders;
    count    = 0;
    tx       = 5'($urandom_range(31));
    ty       = 5'($urandom_range(31));
    row      = 3'($urandom_range(7));
    tile     = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
    row_addr = VRAM_AW'({tile, row, 1'b0});
    if ($urandom_range(99) >= 15) begin
      send_item(make_write(MAP_BASE + VRAM_AW'({ty, tx}), tile));
      count++;
    end
    if ($urandom_range(99) >= 15) begin
      send_item(make_write(row_addr, 8'($urandom_range(255))));
      count++;
    end
    if ($urandom_range(99) >= 15) begin
      send_item(make_write(row_addr + 1'b1, 8'($urandom_range(255))));
      count++;
    end
    renders = $urandom_range(1, 4);
    repeat (renders) begin
      send_item(make_render({tx, 3'($urandom_range(7))}, {ty, row}));
      count++;
    end
  endtask

  initial begin
    int idle_by_phase  [NUM_PHASES];
    int stall_by_phase [NUM_PHASES];
    int sent;
    int burst;
    int kind;
    logic paused;

    idle_by_phase  = '{0, 73, 0, 26};
    stall_by_phase = '{0, 0, 73, 26};
    foreach (vram_mirror[i]) vram_mirror[i] = 8'h00;
    scroll_x_m = '0;
    scroll_y_m = '0;
    foreach (palette_m[i]) palette_m[i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    configure(8'd0, 8'd0, DIR_PAL0, DIR_PAL1, DIR_PAL2, DIR_PAL3);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res);
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1:       configure(8'd255, 8'd255, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        2:       configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                           32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        default: configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                           $urandom, $urandom, $urandom, $urandom);
      endcase
      sender_idle = idle_by_phase[phase];
      stall_pct   = stall_by_phase[phase];
      sent   = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          // hold off the sender until every pending pixel has come back
          drain_results();
          paused = 1'b1;
        end
        kind = $urandom_range(99);
        if (kind < 60) begin
          send_tile_sequence(burst);
          sent += burst;
        end else if (kind < 80) begin
          send_item(make_render(8'($urandom_range(255)), 8'($urandom_range(255))));
          sent++;
        end else begin
          send_item(make_write(VRAM_AW'($urandom_range(VRAM_BYTES - 1)),
                               8'($urandom_range(255))));
          sent++;
        end
      end
      drain_results();
      stall_pct = 0;
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
